// ----- rtl/block_peak_level_meter_assert.svh -----
// Assertion helpers for the peak level meter.
// Clock and reset are taken from the enclosing module: i_clk, i_rst_n.
`ifndef BLOCK_PEAK_LEVEL_METER_ASSERT_SVH
`define BLOCK_PEAK_LEVEL_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define BPLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define BPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BPLM_ASSERT(lbl, prop, msg)
`define BPLM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/bplm_pkg.sv -----
package bplm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int LVL_W      = 10;
    localparam int DB_W       = 13;
    localparam int SU_W       = 8;
    localparam int AVG_W      = 5;
    localparam int REF_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;

    localparam logic [MAG_W-1:0] FULL_SCALE = 15'd32767;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DB    = 1'b1;

    // 320*log10(2) in Q24
    localparam logic [30:0] C_LOG10_2_Q24 = 31'd1616142483;

    typedef struct packed {
        logic take;
        logic sum_run;
        logic div_init;
        logic div_run;
        logic lvl_start;
        logic lvl_sel;      // 0: block peak, 1: mean
        logic cap_peak;
        logic cap_mean;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic ring_full;
        logic sum_done;
        logic div_done;
        logic lvl_done;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/bplm_level.sv -----
module bplm_level
    import bplm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_x,
    output logic             o_done,
    output logic [LVL_W-1:0] o_lvl
);

    typedef enum logic [5:0] {
        P_IDLE = 6'b000001,
        P_INIT = 6'b000010,
        P_SQ   = 6'b000100,
        P_UPD  = 6'b001000,
        P_MUL  = 6'b010000,
        P_RND  = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_done;
    logic [4:0]  r_it;
    logic [8:0]  r_n;
    logic [3:0]  r_e;
    logic [31:0] r_y;
    logic [31:0] r_frac;
    logic [63:0] r_prod;
    logic [LVL_W-1:0] r_lvl;

    // n = max(1, ceil(x*508/32767)); quotient by 32767 is v>>15 or one more
    logic [23:0] v;
    logic [8:0]  q0;
    logic [23:0] qm;
    logic [23:0] rem;
    logic [8:0]  q;
    logic [8:0]  n_calc;

    always_comb begin
        v      = ({9'd0, i_x} << 9) - ({9'd0, i_x} << 2) + 24'd32766;
        q0     = v[23:15];
        qm     = {q0, 15'd0} - {15'd0, q0};
        rem    = v - qm;
        q      = (rem >= 24'd32767) ? q0 + 9'd1 : q0;
        n_calc = (q == 9'd0) ? 9'd1 : q;
    end

    logic [3:0]  e_calc;
    logic [39:0] n_sh;
    logic [31:0] y_init;

    always_comb begin
        e_calc = 4'd0;
        for (int i = 0; i < 9; i++) begin
            if (r_n[i]) begin
                e_calc = 4'(i);
            end
        end
        n_sh   = {r_n, 31'd0} >> e_calc;
        y_init = n_sh[31:0];
    end

    logic [63:0] sq_p;
    logic [64:0] sq_rnd;
    logic [33:0] t;
    logic [31:0] y_next;
    logic [31:0] mul_a;
    logic [62:0] mul_p;
    logic [63:0] lvl_rnd;

    always_comb begin
        sq_p    = r_y * r_y;
        sq_rnd  = {1'b0, r_prod} + 65'h0_4000_0000;
        t       = sq_rnd[64:31];
        y_next  = t[32] ? t[32:1] : t[31:0];
        mul_a   = {r_e, r_frac[31:4]};
        mul_p   = mul_a * C_LOG10_2_Q24;
        lvl_rnd = r_prod + 64'h0008_0000_0000_0000;
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_phase = P_INIT;
                end
            end
            P_INIT: n_phase = P_SQ;
            P_SQ:   n_phase = P_UPD;
            P_UPD: begin
                n_phase = (r_it == 5'd31) ? P_MUL : P_SQ;
            end
            P_MUL:  n_phase = P_RND;
            P_RND:  n_phase = P_IDLE;
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == P_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    r_n <= n_calc;
                end
            end
            P_INIT: begin
                r_e    <= e_calc;
                r_y    <= y_init;
                r_frac <= '0;
                r_it   <= '0;
            end
            P_SQ: begin
                r_prod <= sq_p;
            end
            P_UPD: begin
                r_y    <= y_next;
                r_frac <= {r_frac[30:0], t[32]};
                r_it   <= r_it + 5'd1;
            end
            P_MUL: begin
                r_prod <= {1'b0, mul_p};
            end
            P_RND: begin
                r_lvl <= lvl_rnd[61:52];
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_lvl  = r_lvl;

endmodule

// ----- rtl/bplm_ctrl.sv -----
module bplm_ctrl
    import bplm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SUM     = 8'b0000_0010,
        ST_DIV     = 8'b0000_0100,
        ST_LP_GO   = 8'b0000_1000,
        ST_LP_WAIT = 8'b0001_0000,
        ST_LM_GO   = 8'b0010_0000,
        ST_LM_WAIT = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_status.last && i_status.ring_full) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum_run = 1'b1;
                if (i_status.sum_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_run = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_LP_GO;
                end
            end
            ST_LP_GO: begin
                o_cmd.lvl_start = 1'b1;
                n_state         = ST_LP_WAIT;
            end
            ST_LP_WAIT: begin
                if (i_status.lvl_done) begin
                    o_cmd.cap_peak = 1'b1;
                    n_state        = ST_LM_GO;
                end
            end
            ST_LM_GO: begin
                o_cmd.lvl_start = 1'b1;
                o_cmd.lvl_sel   = 1'b1;
                n_state         = ST_LM_WAIT;
            end
            ST_LM_WAIT: begin
                o_cmd.lvl_sel = 1'b1;
                if (i_status.lvl_done) begin
                    o_cmd.cap_mean = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ----- rtl/bplm_dpath.sv -----
`include "block_peak_level_meter_assert.svh"
module bplm_dpath
    import bplm_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_last,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > AVG_W) ? CNT_W : AVG_W;
    localparam int SUM_W  = MAG_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);

    // configuration
    logic [AVG_W-1:0] r_avg;
    logic [REF_W-1:0] r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= AVG_W'(1);
            r_ref <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_AVG_COUNT: r_avg <= i_cfg_wdata[AVG_W-1:0];
                CFG_REF_DB:    r_ref <= i_cfg_wdata;
            endcase
        end
    end

    // sample magnitude, saturated
    logic [SAMPLE_W-1:0] neg;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    r_max, r_min;
    logic [MAG_W-1:0]    new_max, new_min;

    always_comb begin
        neg     = ~i_sample + 16'd1;
        if (i_sample[SAMPLE_W-1]) begin
            mag = neg[SAMPLE_W-1] ? FULL_SCALE : neg[MAG_W-1:0];
        end else begin
            mag = i_sample[MAG_W-1:0];
        end
        new_max = (mag > r_max) ? mag : r_max;
        new_min = (mag < r_min) ? mag : r_min;
    end

    // ring position and effective count
    logic [PTR_W-1:0] r_pos;
    logic [CMP_W-1:0] avg_ext;
    logic [CNT_W-1:0] eff_cnt;
    logic [CNT_W-1:0] pos_inc;
    logic             ring_full;
    logic             block_end;

    always_comb begin
        avg_ext = CMP_W'(r_avg);
        if (r_avg == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (avg_ext > CMP_W'(RING_DEPTH)) begin
            eff_cnt = DEPTH_C;
        end else begin
            eff_cnt = CNT_W'(avg_ext);
        end
        pos_inc   = CNT_W'(r_pos) + CNT_W'(1);
        ring_full = (pos_inc >= eff_cnt);
        block_end = i_cmd.take && i_last;
    end

    // sum and divide
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_vld;
    logic [MAG_W-1:0]  r_rd_data;
    logic [SUM_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [MAG_W-1:0]  r_pmax, r_pmin;
    logic [MAG_W-1:0]  r_ring [RING_DEPTH];
    logic              sum_done, div_done;
    logic [CNT_W:0]    rem_sh, rem_sub;
    logic              quo_bit;

    always_comb begin
        sum_done = (r_idx == r_cnt) && !r_rd_vld;
        div_done = (r_step == STEP_W'(SUM_W));
        rem_sh   = {r_rem, r_acc[SUM_W-1]};
        rem_sub  = rem_sh - {1'b0, r_cnt};
        quo_bit  = (rem_sh >= {1'b0, r_cnt});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= '0;
            r_min    <= FULL_SCALE;
            r_pos    <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_step   <= '0;
        end else begin
            if (i_cmd.take) begin
                if (i_last) begin
                    r_max <= '0;
                    r_min <= FULL_SCALE;
                    r_pos <= ring_full ? '0 : PTR_W'(pos_inc);
                    if (ring_full) begin
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end else begin
                    r_max <= new_max;
                    r_min <= new_min;
                end
            end
            if (i_cmd.sum_run) begin
                r_rd_vld <= (r_idx < r_cnt);
                if (r_idx < r_cnt) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_cmd.div_init) begin
                r_step <= '0;
            end else if (i_cmd.div_run && !div_done) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // ring memory: never read before written within the current pass
    always_ff @(posedge i_clk) begin
        if (block_end) begin
            r_ring[r_pos] <= new_max;
        end
        r_rd_data <= r_ring[r_idx[PTR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (block_end) begin
            r_pmax <= new_max;
            r_pmin <= new_min;
            if (ring_full) begin
                r_cnt <= eff_cnt;
                r_acc <= '0;
            end
        end
        if (i_cmd.sum_run && r_rd_vld) begin
            r_acc <= r_acc + SUM_W'(r_rd_data);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
        end else if (i_cmd.div_run && !div_done) begin
            // restoring long division, quotient shifts into the dividend
            r_rem <= quo_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_acc <= {r_acc[SUM_W-2:0], quo_bit};
        end
    end

    // level unit, shared by peak and mean
    logic [MAG_W-1:0] lvl_x;
    logic             lvl_done;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] r_lvl_p, r_lvl_m;

    assign lvl_x = i_cmd.lvl_sel ? r_acc[MAG_W-1:0] : r_pmax;

    bplm_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lvl_start),
        .i_x     (lvl_x),
        .o_done  (lvl_done),
        .o_lvl   (lvl)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_peak) begin
            r_lvl_p <= lvl;
        end
        if (i_cmd.cap_mean) begin
            r_lvl_m <= lvl;
        end
    end

    // result fields; S-units = lvl/6 via 683/4096, exact for lvl <= 866
    logic [DB_W-1:0] ref16;
    logic [DB_W-1:0] db_p, db_m;
    logic [19:0]     su_p_m, su_m_m;

    always_comb begin
        ref16  = {r_ref[REF_W-1], r_ref, 4'b0000};
        db_p   = DB_W'(r_lvl_p) - ref16;
        db_m   = DB_W'(r_lvl_m) - ref16;
        su_p_m = r_lvl_p * 10'd683;
        su_m_m = r_lvl_m * 10'd683;
    end

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= {1'b0, su_m_m[19:12], su_p_m[19:12], db_m, db_p,
                           r_acc[MAG_W-1:0], r_pmin, r_pmax};
        end
    end

    always_comb begin
        o_status.last      = i_last;
        o_status.ring_full = ring_full;
        o_status.sum_done  = sum_done;
        o_status.div_done  = div_done;
        o_status.lvl_done  = lvl_done;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `BPLM_ASSERT(a_pos_below_depth, CNT_W'(r_pos) < DEPTH_C, "ring position past depth")
    `BPLM_ASSERT(a_sum_idx_bound, !i_cmd.sum_run || r_idx <= r_cnt, "ring read past count")
    `BPLM_ASSERT(a_quo_fits, !(i_cmd.div_run && div_done) || r_acc[SUM_W-1:MAG_W] == '0, "mean too wide")
    `BPLM_ASSERT_NEXT(a_load_shows, i_cmd.load, r_out_valid, "loaded result not presented")

endmodule

// ----- rtl/block_peak_level_meter.sv -----
// Samples are taken one per cycle while no result is being computed.
// A block end that completes the ring stalls input while its result is computed: the
// ring sum, the mean divide and two level computations (peak and mean, each with
// 32 squaring steps in the log2 unit).
// The result then sits in an output register, so input resumes; the next one waits for it.
// Synchronous active-low reset clears control, counters and config; ring contents are not reset.
module block_peak_level_meter
    import bplm_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [15:0] sample
    input  logic                  i_s_axis_tlast,   // last_in_block
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [14:0] peak, [29:15] trough, [44:30] mean_peak, [57:45] peak_db,
    // [70:58] mean_db, [78:71] peak_s_units, [86:79] mean_s_units, [87] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    bplm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bplm_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// ----- bench/tb_block_peak_level_meter.sv -----
module tb_block_peak_level_meter;
    import bplm_pkg::*;

    localparam int RING_SLOTS    = 16;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } sample_req_t;

    // field order matches o_m_axis_tdata, MSB first
    typedef struct packed {
        logic                    pad;
        logic [SU_W-1:0]         mean_su;
        logic [SU_W-1:0]         peak_su;
        logic signed [DB_W-1:0]  mean_db;
        logic signed [DB_W-1:0]  peak_db;
        logic [MAG_W-1:0]        mean_peak;
        logic [MAG_W-1:0]        trough;
        logic [MAG_W-1:0]        peak;
    } meter_reading_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_last = 1'b0;
    logic                  m_ready = 1'b0;
    logic                  cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_AVG_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire [OUT_DATA_W-1:0]  m_data;

    sample_req_t    sample_q[$];
    meter_reading_t pending_readings[$];
    logic           in_fire = 1'b0;
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    // predictor state
    int unsigned        blk_max;
    int unsigned        blk_min;
    int unsigned        peak_store[RING_SLOTS];
    int unsigned        ring_pos;
    logic [AVG_W-1:0]   avg_cfg;
    logic signed [7:0]  ref_cfg;

    block_peak_level_meter #(.RING_DEPTH(RING_SLOTS)) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [15:0] sample
        .i_s_axis_tlast  (s_last),    // last_in_block
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // [14:0] peak, [29:15] trough, [44:30] mean_peak, [57:45] peak_db,
        // [70:58] mean_db, [78:71] peak_s_units, [86:79] mean_s_units
        .o_m_axis_tdata  (m_data),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_data)
    );

    always #10 clk = ~clk;

    // 20*log10(n) in Q.4, n = ceil(x*508/32767) clamped to at least 1
    function automatic int level_q4(input int unsigned x);
        int unsigned n;
        int unsigned e;
        int unsigned frac;
        bit [63:0]   y;
        bit [63:0]   lq;
        bit [63:0]   prod;
        n = (x * 508 + 32766) / 32767;
        if (n < 1) n = 1;
        e = 0;
        while ((n >> (e + 1)) != 0) e++;
        y = (64'(n) << 31) >> e;
        frac = 0;
        for (int k = 0; k < 32; k++) begin
            y = (y * y + (64'd1 << 30)) >> 31;
            frac = frac << 1;
            if (y >= (64'd2 << 31)) begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        lq = (64'(e) << 32) | 64'(frac);
        prod = (lq >> 4) * 64'(C_LOG10_2_Q24);
        return int'((prod + (64'd1 << 51)) >> 52);
    endfunction

    function automatic void meter_reset();
        blk_max = 0;
        blk_min = 32767;
        ring_pos = 0;
        avg_cfg = 5'd1;
        ref_cfg = 8'sd0;
        foreach (peak_store[k]) peak_store[k] = 0;
    endfunction

    function automatic void meter_predict(input logic [SAMPLE_W-1:0] s, input logic is_last);
        int unsigned    mag;
        int unsigned    pmax;
        int unsigned    pmin;
        int unsigned    cnt;
        int unsigned    mean;
        longint unsigned total;
        int             lp;
        int             lm;
        int             dbp;
        int             dbm;
        meter_reading_t r;
        mag = s[15] ? 32'd65536 - 32'(s) : 32'(s);
        if (mag > 32767) mag = 32767;   // -32768 saturates
        if (mag > blk_max) blk_max = mag;
        if (mag < blk_min) blk_min = mag;
        if (!is_last) return;
        pmax = blk_max;
        pmin = blk_min;
        blk_max = 0;
        blk_min = 32767;
        cnt = (avg_cfg == 0) ? 1 : ((avg_cfg > RING_SLOTS) ? RING_SLOTS : avg_cfg);
        if (ring_pos < RING_SLOTS) peak_store[ring_pos] = pmax;
        ring_pos++;
        if (ring_pos < cnt) return;
        total = 0;
        for (int k = 0; k < cnt; k++) total += peak_store[k];
        mean = int'(total / cnt);
        ring_pos = 0;
        lp = level_q4(pmax);
        lm = level_q4(mean);
        dbp = lp - 16 * ref_cfg;
        dbm = lm - 16 * ref_cfg;
        r = '0;
        r.peak = pmax[MAG_W-1:0];
        r.trough = pmin[MAG_W-1:0];
        r.mean_peak = mean[MAG_W-1:0];
        r.peak_db = dbp[DB_W-1:0];
        r.mean_db = dbm[DB_W-1:0];
        r.peak_su = 8'(lp / 6);
        r.mean_su = 8'(lm / 6);
        pending_readings.push_back(r);
    endfunction

    function automatic void check_field(input string fname, input int want, input int got_v);
        if (want != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, fname, want, got_v);
            mismatch_count++;
        end
    endfunction

    // monitor: config shadow, result check, prediction on accepted requests
    always @(posedge clk) begin
        meter_reading_t want;
        meter_reading_t got_r;
        if (!rst_n) begin
            meter_reset();
            in_fire <= 1'b0;
        end else begin
            if (cfg_en) begin
                case (cfg_idx)
                    CFG_AVG_COUNT: avg_cfg = cfg_data[AVG_W-1:0];
                    CFG_REF_DB:    ref_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got_r = meter_reading_t'(m_data);
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, m_data);
                    mismatch_count++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("peak", want.peak, got_r.peak);
                    check_field("trough", want.trough, got_r.trough);
                    check_field("mean_peak", want.mean_peak, got_r.mean_peak);
                    check_field("peak_db", want.peak_db, got_r.peak_db);
                    check_field("mean_db", want.mean_db, got_r.mean_db);
                    check_field("peak_s_units", want.peak_su, got_r.peak_su);
                    check_field("mean_s_units", want.mean_su, got_r.mean_su);
                end
            end
            if (s_valid && s_ready) meter_predict(s_data, s_last);
            in_fire <= s_valid && s_ready;
        end
    end

    // driver: hold a request until taken, then the next one or an idle cycle
    always @(negedge clk) begin
        sample_req_t req;
        if (rst_n) begin
            if (!s_valid || in_fire) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = sample_q.pop_front();
                    s_valid <= 1'b1;
                    s_data <= req.sample;
                    s_last <= req.is_last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_req(input logic [SAMPLE_W-1:0] s, input logic is_last);
        sample_req_t req;
        req.sample = s;
        req.is_last = is_last;
        sample_q.push_back(req);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h8001;
            4: return 16'($urandom_range(200)) ^ {16{$urandom_range(1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    // one block of random length, mostly short
    task automatic push_block(inout int count);
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) push_req(rand_sample(), k == len - 1);
        count += len;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // wait until every request is taken and every result has come,
    // then let a possible in-flight computation finish
    task automatic drain();
        while (sample_q.size() != 0 || s_valid) @(posedge clk);
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 80; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default:       begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    int unsigned phase_avg[8] = '{16, 31, 2, 5, 1, 12, 0, 9};
    int          phase_ref[8] = '{127, -128, -1, 40, 0, -60, 1, 100};

    initial begin
        int count;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // defaults: one block per result
        set_idle(IDLE_NONE);
        push_req(16'h7FFF, 1'b1);
        push_req(16'h8000, 1'b1);
        push_req(16'h0000, 1'b1);
        push_req(16'h0001, 1'b0);
        push_req(16'hFFFF, 1'b0);
        push_req(16'h0000, 1'b1);
        push_req(16'h8001, 1'b0);
        push_req(16'h4000, 1'b1);
        push_req(16'h0040, 1'b1);
        push_req(16'h0041, 1'b0);
        push_req(16'hFFBE, 1'b1);
        drain();

        // zero count acts as one; reference extremes
        write_reg(CFG_AVG_COUNT, 8'd0);
        write_reg(CFG_REF_DB, 8'h7F);
        push_req(16'h8000, 1'b1);
        push_req(16'h0000, 1'b1);
        drain();
        write_reg(CFG_REF_DB, 8'h80);
        push_req(16'h7FFF, 1'b1);
        drain();

        // count lowered mid-ring: result at the next block end over the first entries
        write_reg(CFG_AVG_COUNT, 8'd8);
        push_req(16'h7FFF, 1'b1);
        push_req(16'h1234, 1'b1);
        push_req(16'h8000, 1'b1);
        push_req(16'h0100, 1'b1);
        push_req(16'hF000, 1'b1);
        drain();
        write_reg(CFG_AVG_COUNT, 8'd3);
        push_req(16'h0002, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_AVG_COUNT, 8'(phase_avg[p]));
            write_reg(CFG_REF_DB, 8'(phase_ref[p]));
            set_idle(idle_mode_t'(p % 4));
            count = 0;
            while (count < 210) push_block(count);
            drain();
        end

        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bplm_pkg.sv
rtl/bplm_level.sv
rtl/bplm_ctrl.sv
rtl/bplm_dpath.sv
rtl/block_peak_level_meter.sv
bench/tb_block_peak_level_meter.sv
